>>> hdl/faa_pkg.sv
package faa_pkg;

  localparam int MaxBlocks = 8;
  localparam int SizeBits  = 16;
  localparam int BlkW      = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CntW      = $clog2(MaxBlocks + 1);
  localparam int IdxW      = 3;
  localparam int AmtW      = 16;
  localparam int ReqNumW   = 16;
  localparam int CfgW      = 4;
  localparam int CfgIdxW   = 1;
  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic OpLoad    = 1'b0;
  localparam logic OpRequest = 1'b1;

  localparam logic [CfgIdxW-1:0] RegBlocksInUse = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFitMode     = 1'b1;

  localparam logic FitFirst = 1'b0;
  localparam logic FitWorst = 1'b1;

  typedef enum logic {
    KindLoad,
    KindRequest
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [BlkW-1:0]     blk;
    logic [SizeBits-1:0] amt;
  } job_t;

  typedef struct packed {
    logic [CntW-1:0] limit;
    logic            mode;
  } cfg_t;

endpackage

>>> hdl/faa_if.sv
interface faa_in_if import faa_pkg::*; ;
  logic            valid;
  logic            ready;
  logic            op;
  logic [IdxW-1:0] block_index;
  logic [AmtW-1:0] amount;

  modport source (output valid, op, block_index, amount, input ready);
  modport sink (input valid, op, block_index, amount, output ready);
endinterface

interface faa_out_if import faa_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               granted;
  logic [IdxW-1:0]    chosen_block;
  logic [AmtW-1:0]    remaining_free;
  logic [ReqNumW-1:0] request_number;

  modport source (output valid, granted, chosen_block, remaining_free, request_number,
                  input ready);
  modport sink (input valid, granted, chosen_block, remaining_free, request_number,
                output ready);
endinterface

>>> hdl/faa_front.sv
module faa_front import faa_pkg::*; (
  faa_in_if.sink in_i,
  input  logic   q_full_i,
  output logic   push_o,
  output job_t   job_o
);

  logic in_range;
  logic accept;

  assign in_range    = 32'(in_i.block_index) < MaxBlocks;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && !q_full_i;

  // A load aimed beyond the table is dropped here and never reaches the queue.
  assign push_o      = accept && ((in_i.op == OpRequest) || in_range);
  assign job_o.kind  = (in_i.op == OpRequest) ? KindRequest : KindLoad;
  assign job_o.blk   = BlkW'(in_i.block_index);
  assign job_o.amt   = SizeBits'(in_i.amount);

endmodule

>>> hdl/faa_queue.sv
module faa_queue import faa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (32'(wr_q) == QDepth - 1) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (32'(rd_q) == QDepth - 1) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

>>> hdl/faa_back.sv
module faa_back import faa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  faa_out_if.source out_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SDone = 2'd2;

  logic [1:0]          state_q;
  logic [SizeBits-1:0] free_q [MaxBlocks];
  logic [BlkW-1:0]     idx_q;
  logic [SizeBits-1:0] amt_q;
  logic                found_q;
  logic [BlkW-1:0]     pick_q;
  logic [SizeBits-1:0] best_q;
  logic [ReqNumW-1:0]  count_q;

  logic                ovalid_q;
  logic                ogranted_q;
  logic [IdxW-1:0]     oblk_q;
  logic [AmtW-1:0]     oleft_q;
  logic [ReqNumW-1:0]  onum_q;

  logic [SizeBits-1:0] cur;
  logic                fits;
  logic                take;
  logic                last;
  logic                out_free;
  logic [SizeBits-1:0] left;

  assign cur      = free_q[idx_q];
  assign fits     = cur >= amt_q;
  assign take     = fits && (!found_q || (cur > best_q));
  assign last     = (CntW'(idx_q) + CntW'(1) == cfg_i.limit)
                    || (fits && !found_q && (cfg_i.mode == FitFirst));
  assign out_free = !ovalid_q || out_o.ready;
  assign left     = best_q - amt_q;
  assign pop_o    = (state_q == SIdle) && job_valid_i;

  assign out_o.valid          = ovalid_q;
  assign out_o.granted        = ogranted_q;
  assign out_o.chosen_block   = oblk_q;
  assign out_o.remaining_free = oleft_q;
  assign out_o.request_number = onum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
      count_q  <= '0;
      found_q  <= 1'b0;
      for (int k = 0; k < MaxBlocks; k++) begin
        free_q[k] <= '0;
      end
    end else begin
      if (ovalid_q && out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (job_valid_i) begin
            if (job_i.kind == KindLoad) begin
              free_q[job_i.blk] <= job_i.amt;
            end else begin
              found_q <= 1'b0;
              state_q <= (cfg_i.limit == '0) ? SDone : SScan;
            end
          end
        end
        SScan: begin
          if (take) begin
            found_q <= 1'b1;
          end
          if (last) begin
            state_q <= SDone;
          end
        end
        SDone: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            count_q  <= count_q + 1'b1;
            if (found_q) begin
              free_q[pick_q] <= left;
            end
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        idx_q  <= '0;
        amt_q  <= job_i.amt;
        pick_q <= '0;
        best_q <= '0;
      end
      SScan: begin
        idx_q <= idx_q + 1'b1;
        if (take) begin
          pick_q <= idx_q;
          best_q <= cur;
        end
      end
      SDone: begin
        if (out_free) begin
          ogranted_q <= found_q;
          oblk_q     <= found_q ? IdxW'(pick_q) : '0;
          oleft_q    <= found_q ? AmtW'(left) : '0;
          onum_q     <= count_q;
        end
      end
      default: begin
        idx_q <= '0;
      end
    endcase
  end

endmodule

>>> hdl/first_or_worst_fit_allocator.sv
// Allocator over a table of eight free sizes, all zero after reset. A load item writes one
// block's free size and gives no result; a request item gives exactly one result, granted under
// first fit or worst fit as configured, or refused with block and remaining size zero. Items
// enter a two-deep queue, so the input side keeps accepting while the queue has room and the
// search engine works. The engine reads one table entry per cycle: a load is written while it
// is idle, a request passes through a scan of the blocks searched (first fit stops at the first
// fit) and a done state, and a finished result waits in an output register until taken.
// Configuration must only be written while no item is in flight.
module first_or_worst_fit_allocator import faa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  faa_in_if.sink             in_i,
  faa_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [CfgW-1:0] blocks_in_use_q;
  logic            fit_mode_q;
  cfg_t            cfg;
  logic            q_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  job_t            push_job;
  job_t            head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= CfgW'(8);
      fit_mode_q      <= FitFirst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBlocksInUse: blocks_in_use_q <= cfg_data_i;
        RegFitMode:     fit_mode_q      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.limit = (32'(blocks_in_use_q) > MaxBlocks) ? CntW'(MaxBlocks)
                                                         : CntW'(blocks_in_use_q);
  assign cfg.mode  = fit_mode_q;

  faa_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (push_job)
  );

  faa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  faa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.granted) |-> (32'(out_o.chosen_block) < 32'(cfg.limit)))
    else $error("granted block lies outside the searched range");

  a_refusal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.granted) |-> (out_o.chosen_block == '0 && out_o.remaining_free == '0))
    else $error("refused request carries a block or a size");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("item pushed into a full queue");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

>>> tb/testbench.sv
module testbench import faa_pkg::*; ;

  localparam int QuietLimit = 4000;
  localparam int SettleCycles = 16;

  typedef struct packed {
    logic               granted;
    logic [IdxW-1:0]    chosen_block;
    logic [AmtW-1:0]    remaining_free;
    logic [ReqNumW-1:0] request_number;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [SizeBits-1:0] free_size [MaxBlocks];
    logic [ReqNumW-1:0]  request_count;
    logic [CfgW-1:0]     blocks_in_use;
    logic                fit_mode;
    alloc_result_t       awaited [$];
    int errors;
    int loads;
    int requests;
    int grants;
    int refusals;

    function new();
      foreach (free_size[k]) free_size[k] = '0;
      request_count = '0;
      blocks_in_use = CfgW'(8);
      fit_mode = FitFirst;
    endfunction

    // Applies a load to the table, or works out the allocation a request causes and updates the table.
    function void note_item(logic op, logic [IdxW-1:0] idx, logic [AmtW-1:0] amount);
      int limit;
      int pick;
      bit found;
      alloc_result_t r;
      if (op == OpLoad) begin
        if (idx < MaxBlocks) free_size[idx] = amount;
        loads++;
        return;
      end
      limit = (blocks_in_use > MaxBlocks) ? MaxBlocks : int'(blocks_in_use);
      found = 1'b0;
      pick = 0;
      for (int j = 0; j < limit; j++) begin
        if (free_size[j] >= amount) begin
          if (!found) begin
            found = 1'b1;
            pick = j;
            if (fit_mode == FitFirst) break;
          end else if (free_size[j] > free_size[pick]) begin
            pick = j;
          end
        end
      end
      r.granted = found;
      r.chosen_block = IdxW'(pick);
      if (found) begin
        free_size[pick] = free_size[pick] - amount;
        r.remaining_free = free_size[pick];
        grants++;
      end else begin
        r.remaining_free = '0;
        refusals++;
      end
      r.request_number = request_count;
      request_count = request_count + 1'b1;
      requests++;
      awaited.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding: granted %0d, block %0d, left %0d, number %0d",
               got.granted, got.chosen_block, got.remaining_free, got.request_number);
        errors++;
        return;
      end
      want = awaited.pop_front();
      check_field("granted", 32'(want.granted), 32'(got.granted));
      check_field("chosen_block", 32'(want.chosen_block), 32'(got.chosen_block));
      check_field("remaining_free", 32'(want.remaining_free), 32'(got.remaining_free));
      check_field("request_number", 32'(want.request_number), 32'(got.request_number));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  faa_in_if  in_if ();
  faa_out_if out_if ();

  first_or_worst_fit_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  alloc_scoreboard sb;
  bit idle_on;
  int quiet_cycles;
  int settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Results are checked before the item of the same edge is noted, so a stray
  // result can never match a request that was only just accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result({out_if.granted, out_if.chosen_block, out_if.remaining_free,
                         out_if.request_number});
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_item(in_if.op, in_if.block_index, in_if.amount);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    wait (quiet_cycles >= QuietLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(logic op, logic [IdxW-1:0] idx, logic [AmtW-1:0] amt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.block_index <= idx;
    in_if.amount <= amt;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [CfgW-1:0] limit, logic mode);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegBlocksInUse;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_index_i <= RegFitMode;
    cfg_data_i <= CfgW'(mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.blocks_in_use = limit;
    sb.fit_mode = mode;
    settings_used++;
  endtask

  // Mostly loads and requests sized against the table so that grants, exact
  // fits and near misses all occur; the rest is full-range noise.
  task automatic send_random_item();
    logic            op;
    logic [IdxW-1:0] idx;
    logic [AmtW-1:0] amt;
    int              k;
    idx = IdxW'($urandom_range(0, 7));
    k = $urandom_range(0, MaxBlocks - 1);
    if ($urandom_range(0, 99) < 30) begin
      op = OpLoad;
      case ($urandom_range(0, 3))
        0: amt = AmtW'($urandom);
        1: amt = AmtW'($urandom_range(0, 300));
        2: amt = AmtW'(1000 * $urandom_range(1, 3));
        default: amt = AmtW'(16'hFFFF - $urandom_range(0, 2));
      endcase
    end else begin
      op = OpRequest;
      case ($urandom_range(0, 4))
        0: amt = '0;
        1: amt = AmtW'($urandom_range(1, 200));
        2: amt = sb.free_size[k];
        3: amt = sb.free_size[k] + 1'b1;
        default: amt = AmtW'($urandom);
      endcase
    end
    send_item(op, idx, amt);
  endtask

  initial begin
    logic [CfgW-1:0] limit;
    logic            mode;
    sb = new();
    idle_on = 1'b1;
    quiet_cycles = 0;
    settings_used = 1;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.op <= OpLoad;
    in_if.block_index <= '0;
    in_if.amount <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= RegBlocksInUse;
    cfg_data_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: a zero-size request still fits block zero, others are refused.
    send_item(OpRequest, 3'd5, 16'd0);
    send_item(OpRequest, 3'd0, 16'd1);
    send_item(OpRequest, 3'd7, 16'hFFFF);
    send_item(OpLoad, 3'd0, 16'd100);
    send_item(OpLoad, 3'd1, 16'hFFFF);
    send_item(OpLoad, 3'd2, 16'd50);
    send_item(OpLoad, 3'd3, 16'hFFFF);
    send_item(OpLoad, 3'd4, 16'd0);
    send_item(OpLoad, 3'd5, 16'd200);
    send_item(OpLoad, 3'd6, 16'h8000);
    send_item(OpLoad, 3'd7, 16'h7FFF);
    send_item(OpRequest, 3'd2, 16'd60);
    send_item(OpRequest, 3'd0, 16'hFFFF);
    send_item(OpRequest, 3'd0, 16'd0);

    // Worst fit, ending on a three-way tie that the lowest index must win.
    apply_setting(CfgW'(8), FitWorst);
    send_item(OpRequest, 3'd0, 16'd0);
    send_item(OpRequest, 3'd0, 16'h8000);
    send_item(OpRequest, 3'd0, 16'd1);
    send_item(OpRequest, 3'd0, 16'h7FFF);

    apply_setting(CfgW'(0), FitWorst);
    send_item(OpRequest, 3'd0, 16'd0);

    apply_setting(CfgW'(15), FitFirst);
    send_item(OpRequest, 3'd0, 16'h7FFF);
    send_item(OpRequest, 3'd0, 16'd1);

    apply_setting(CfgW'(1), FitWorst);
    send_item(OpRequest, 3'd0, 16'd41);
    send_item(OpRequest, 3'd0, 16'd39);

    for (int p = 0; p < 20; p++) begin
      case (p)
        0: begin limit = CfgW'(8);  mode = FitFirst; end
        1: begin limit = CfgW'(8);  mode = FitWorst; end
        2: begin limit = CfgW'(1);  mode = FitFirst; end
        3: begin limit = CfgW'(1);  mode = FitWorst; end
        4: begin limit = CfgW'(0);  mode = FitFirst; end
        5: begin limit = CfgW'(15); mode = FitWorst; end
        6: begin limit = CfgW'(9);  mode = FitFirst; end
        default: begin
          limit = ($urandom_range(0, 3) == 0) ? CfgW'($urandom_range(0, 15))
                                                : CfgW'($urandom_range(1, 8));
          mode = 1'($urandom_range(0, 1));
        end
      endcase
      apply_setting(limit, mode);
      idle_on = (p % 4 != 3);
      repeat (100) send_random_item();
    end

    drain();
    $display("Run covered %0d loads and %0d requests (%0d granted, %0d refused)",
             sb.loads, sb.requests, sb.grants, sb.refusals);
    $display("across %0d search-count and policy settings, with and without stalls.",
             settings_used);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
